// ===== rtl/core/rgbfx_pkg.sv =====
package rgbfx_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HUE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SAT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_VALUE   = 3'd4;

    localparam logic [7:0] HUE_STRIDE   = 8'd16;
    localparam logic [7:0] BREATH_LIMIT = 8'd62;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DRAW,
        ST_FINISH,
        ST_EMIT
    } state_t;

    // datapath commands, one phase per state
    typedef struct packed {
        logic start;
        logic update;
        logic draw;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic draw_done;
        logic emit_done;
    } status_t;

    function automatic logic [7:0] breath_level(input logic [5:0] idx);
        logic [7:0] t [64];
        t = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
              8'd0, 8'd0, 8'd1, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5,
              8'd6, 8'd8, 8'd10, 8'd12, 8'd15, 8'd17, 8'd20, 8'd24,
              8'd28, 8'd32, 8'd36, 8'd41, 8'd46, 8'd51, 8'd57, 8'd63,
              8'd70, 8'd76, 8'd83, 8'd91, 8'd98, 8'd106, 8'd113, 8'd121,
              8'd129, 8'd138, 8'd146, 8'd154, 8'd162, 8'd170, 8'd178, 8'd185,
              8'd193, 8'd200, 8'd207, 8'd213, 8'd220, 8'd225, 8'd231, 8'd235,
              8'd240, 8'd244, 8'd247, 8'd250, 8'd252, 8'd253, 8'd254, 8'd255};
        return t[idx];
    endfunction

endpackage

// ===== rtl/core/rgbfx_stream_if.sv =====
interface rgbfx_stream_if #(
    parameter int unsigned WIDTH = 1
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/rgb_led_effect_generator.sv =====
// channel  | dir | payload                                    | handshake
// in_if    | in  | battery_low                                | valid/ready
// out_if   | out | pixel_index, red, green, blue, frame_end   | valid/ready
// cfg      | in  | cfg_we, cfg_index, cfg_data                | write only
//
// one request (tick) runs, from accept to next accept: accept, an update
// state, a draw sweep through the two-stage hsv unit into the frame ram,
// a closing state, then the readout, one pixel a cycle while the output
// is not stalled
// an ignored request (disabled or battery low) goes back to idle from update
// reset sets all effect state to its start values; the frame store reads
// as black until written, tracked by per-entry valid bits
// output stalls hold the output register and pause the readout
module rgb_led_effect_generator #(
    parameter int unsigned LED_COUNT     = 16,
    parameter int unsigned SNAKE_LENGTH  = 4,
    parameter int unsigned KNIGHT_LENGTH = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    rgbfx_stream_if.sink                       in_if,
    rgbfx_stream_if.source                     out_if,
    input  logic                               cfg_we,
    input  logic [rgbfx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgbfx_pkg::CFG_DATA_W-1:0]   cfg_data
);
    // configuration registers
    logic       light_enable_reg;
    logic [4:0] effect_mode_reg;
    logic [7:0] base_hue_reg;
    logic [7:0] base_sat_reg;
    logic [7:0] base_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_enable_reg <= 1'b0;
            effect_mode_reg  <= 5'd8;
            base_hue_reg     <= 8'd214;
            base_sat_reg     <= 8'd255;
            base_value_reg   <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rgbfx_pkg::REG_LIGHT_ENABLE: light_enable_reg <= cfg_data[0];
                rgbfx_pkg::REG_EFFECT_MODE:  effect_mode_reg  <= cfg_data[4:0];
                rgbfx_pkg::REG_BASE_HUE:     base_hue_reg     <= cfg_data;
                rgbfx_pkg::REG_BASE_SAT:     base_sat_reg     <= cfg_data;
                rgbfx_pkg::REG_BASE_VALUE:   base_value_reg   <= cfg_data;
                default:                     base_hue_reg     <= base_hue_reg;
            endcase
        end
    end

    // control and status between sequencer and datapath
    rgbfx_pkg::cmd_t    cmd;
    rgbfx_pkg::status_t status;

    // tick is captured when the sequencer is idle
    logic battery_low_reg;

    always_ff @(posedge clk)
    begin
        if (in_if.valid && in_if.ready)
        begin
            battery_low_reg <= in_if.payload[0];
        end
    end

    rgbfx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_if.valid),
        .in_ready (in_if.ready),
        .status   (status),
        .cmd      (cmd)
    );

    rgbfx_datapath #(
        .LED_COUNT     (LED_COUNT),
        .SNAKE_LENGTH  (SNAKE_LENGTH),
        .KNIGHT_LENGTH (KNIGHT_LENGTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .battery_low     (cmd.start ? in_if.payload[0] : battery_low_reg),
        .light_enable    (light_enable_reg),
        .effect_mode     (effect_mode_reg),
        .base_hue        (base_hue_reg),
        .base_saturation (base_sat_reg),
        .base_value      (base_value_reg),
        .out_if          (out_if)
    );
endmodule

// ===== rtl/core/rgbfx_hsv.sv =====
// two-stage hsv to rgb: products registered, then sector select registered
module rgbfx_hsv (
    input  logic        clk,
    input  logic [7:0]  hue,
    input  logic [7:0]  sat,
    input  logic [7:0]  val,
    output logic [23:0] rgb
);
    logic [9:0]  h3;
    logic [15:0] hs_prod;
    logic [8:0]  inv_s;
    logic [16:0] lo_prod;
    logic [15:0] hs_reg;
    logic [8:0]  lo_reg;
    logic [1:0]  sect_reg;
    logic [7:0]  v_reg;
    logic [15:0] x_prod;
    logic [7:0]  x;
    logic [7:0]  lo;
    logic [7:0]  t0;
    logic [7:0]  t1;
    logic [23:0] rgb_next;
    logic [23:0] rgb_reg;

    assign h3      = {2'b00, hue} + {1'b0, hue, 1'b0};
    assign hs_prod = h3[7:0] * sat;
    assign inv_s   = 9'd256 - {1'b0, sat};
    assign lo_prod = inv_s * val;

    always_ff @(posedge clk)
    begin
        hs_reg   <= hs_prod;
        lo_reg   <= lo_prod[16:8];
        sect_reg <= h3[9:8];
        v_reg    <= val;
    end

    assign x_prod = hs_reg[15:8] * v_reg;
    assign x      = x_prod[15:8];
    assign lo     = lo_reg[7:0];
    assign t0     = x + lo;
    assign t1     = v_reg - x;

    always_comb
    begin
        case (sect_reg)
            2'd0:    rgb_next = {t1, t0, lo};
            2'd1:    rgb_next = {lo, t1, t0};
            default: rgb_next = {t0, lo, t1};
        endcase
    end

    always_ff @(posedge clk)
    begin
        rgb_reg <= rgb_next;
    end

    assign rgb = rgb_reg;
endmodule

// ===== rtl/core/rgbfx_ram.sv =====
module rgbfx_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/rgbfx_ctrl.sv =====
module rgbfx_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rgbfx_pkg::status_t     status,
    output rgbfx_pkg::cmd_t        cmd
);
    rgbfx_pkg::state_t state_reg;
    rgbfx_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rgbfx_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rgbfx_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rgbfx_pkg::ST_UPDATE;
                end
            end
            rgbfx_pkg::ST_UPDATE:
            begin
                state_next = status.skip ? rgbfx_pkg::ST_IDLE : rgbfx_pkg::ST_DRAW;
            end
            rgbfx_pkg::ST_DRAW:
            begin
                if (status.draw_done)
                begin
                    state_next = rgbfx_pkg::ST_FINISH;
                end
            end
            rgbfx_pkg::ST_FINISH:
            begin
                state_next = rgbfx_pkg::ST_EMIT;
            end
            rgbfx_pkg::ST_EMIT:
            begin
                if (status.emit_done)
                begin
                    state_next = rgbfx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rgbfx_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            rgbfx_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            rgbfx_pkg::ST_UPDATE: cmd.update = 1'b1;
            rgbfx_pkg::ST_DRAW:   cmd.draw   = 1'b1;
            rgbfx_pkg::ST_FINISH: cmd.finish = 1'b1;
            rgbfx_pkg::ST_EMIT:   cmd.emit   = 1'b1;
            default:              cmd        = '0;
        endcase
    end
endmodule

// ===== rtl/core/rgbfx_datapath.sv =====
module rgbfx_datapath #(
    parameter int unsigned LED_COUNT     = 16,
    parameter int unsigned SNAKE_LENGTH  = 4,
    parameter int unsigned KNIGHT_LENGTH = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rgbfx_pkg::cmd_t    cmd,
    output rgbfx_pkg::status_t status,
    input  logic               battery_low,
    input  logic               light_enable,
    input  logic [4:0]         effect_mode,
    input  logic [7:0]         base_hue,
    input  logic [7:0]         base_saturation,
    input  logic [7:0]         base_value,
    rgbfx_stream_if.source     out_if
);
    localparam int unsigned AW = $clog2(LED_COUNT);
    localparam int unsigned CW = AW + 1;
    localparam logic [CW-1:0] LAST = CW'(LED_COUNT - 1);
    localparam logic [7:0] LED8 = 8'(LED_COUNT);
    localparam logic [7:0] SNK8 = 8'(SNAKE_LENGTH);
    localparam logic [7:0] KNT8 = 8'(KNIGHT_LENGTH);
    localparam logic [7:0] HUE_STRIDE_C = rgbfx_pkg::HUE_STRIDE;

    // effect classes
    typedef enum logic [2:0] {
        FX_STATIC, FX_BREATH, FX_MOOD, FX_SWIRL, FX_SNAKE, FX_KNIGHT, FX_NONE
    } fx_t;

    fx_t        fx;
    logic [7:0] m8;
    logic [7:0] interval;

    logic       skip_reg, skip_next;
    logic       paint_reg, paint_next;   // this tick redraws the frame
    logic       clear_reg, clear_next;   // snake/knight: background black
    logic       newheld_reg, newheld_next;
    logic [7:0] hue_reg, hue_next;       // hue of held fill
    logic [7:0] val_reg, val_next;
    logic [7:0] start_reg, start_next;   // drawing origin (snake/knight)
    logic       sdir_reg, sdir_next;

    logic [23:0] held_reg;
    logic [7:0]  bpos_reg;
    logic        brise_reg;
    logic [7:0]  phase_reg;
    logic [7:0]  spos_reg, swait_reg;
    logic [7:0]  kpos_reg, kwait_reg;
    logic        kfwd_reg;

    logic [7:0]  phase_after;   // phase value for knight recolor

    // draw sweep: issue counter and pipeline registers (dv, da1, da2) to the ram
    logic [CW-1:0] dcnt_reg;
    logic [CW-1:0] wcnt_reg;
    logic [1:0]    dv_reg;
    logic [AW-1:0] da1_reg;
    logic [AW-1:0] da2_reg;
    logic          lit1_reg, lit2_reg;
    logic          k1_reg, k2_reg;

    logic [7:0]  h_in;
    logic [23:0] hsv_rgb;

    logic          we;
    logic [23:0]   wdata;
    logic [AW-1:0] raddr;
    logic [23:0]   rdata;
    logic [23:0]   cleared_q;

    // emit: read counter, output register
    logic [CW-1:0] rcnt_reg;
    logic          rpend_reg;
    logic [AW-1:0] rpix_reg;
    logic          ov_reg;
    logic [AW-1:0] opix_reg;
    logic [23:0]   orgb_reg;
    logic          olast_reg;
    logic          olast_pend_reg;

    assign m8 = {3'd0, effect_mode};

    always_comb
    begin
        fx = FX_NONE;
        interval = 8'd0;
        if (effect_mode == 5'd0)       fx = FX_STATIC;
        else if (effect_mode <= 5'd4)  fx = FX_BREATH;
        else if (effect_mode <= 5'd7)  fx = FX_MOOD;
        else if (effect_mode <= 5'd13)
        begin
            fx = FX_SWIRL;
            interval = m8 - 8'd6;
        end
        else if (effect_mode <= 5'd19)
        begin
            fx = FX_SNAKE;
            interval = m8 - 8'd14;
        end
        else if (effect_mode <= 5'd22)
        begin
            fx = FX_KNIGHT;
            interval = m8 - 8'd19;
        end
    end

    // tick decision at start
    always_comb
    begin
        skip_next    = skip_reg;
        paint_next   = paint_reg;
        clear_next   = clear_reg;
        newheld_next = newheld_reg;
        hue_next     = hue_reg;
        val_next     = val_reg;
        start_next   = start_reg;
        sdir_next    = sdir_reg;
        if (cmd.start)
        begin
            skip_next    = battery_low || !light_enable;
            paint_next   = 1'b0;
            clear_next   = 1'b0;
            newheld_next = 1'b0;
            hue_next     = base_hue;
            val_next     = base_value;
            start_next   = 8'd0;
            sdir_next    = 1'b0;
            case (fx)
                FX_STATIC:
                begin
                    paint_next   = 1'b1;
                    newheld_next = 1'b1;
                end
                FX_BREATH:
                begin
                    paint_next   = 1'b1;
                    newheld_next = 1'b1;
                    val_next     = rgbfx_pkg::breath_level(bpos_reg[5:0]);
                end
                FX_MOOD:
                begin
                    paint_next   = 1'b1;
                    newheld_next = 1'b1;
                    hue_next     = phase_reg;
                end
                FX_SWIRL:  paint_next = 1'b1;
                FX_SNAKE:
                begin
                    if (swait_reg + 8'd1 > {1'b0, interval[7:1]})
                    begin
                        paint_next = 1'b1;
                        clear_next = 1'b1;
                    end
                    start_next = spos_reg;
                    sdir_next  = interval[0];
                end
                FX_KNIGHT:
                begin
                    if (kwait_reg + 8'd1 > interval)
                    begin
                        paint_next = 1'b1;
                        clear_next = 1'b1;
                    end
                    start_next = kpos_reg;
                end
                default: paint_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        skip_reg    <= skip_next;
        paint_reg   <= paint_next;
        clear_reg   <= clear_next;
        newheld_reg <= newheld_next;
        hue_reg     <= hue_next;
        val_reg     <= val_next;
        start_reg   <= start_next;
        sdir_reg    <= sdir_next;
    end

    assign status.skip = skip_reg;

    // per-pixel coverage for snake and knight
    logic [CW-1:0] pix;
    logic [7:0]    rel;      // offset of pixel from origin in drawing direction
    logic [7:0]    pix8;
    logic          lit;
    logic [7:0]    snake_base;  // origin reduced mod LED_COUNT
    logic [8:0]    snake_off;

    assign pix  = dcnt_reg;
    assign pix8 = 8'(pix);

    always_comb
    begin
        // origin is signed, from -SNAKE_LENGTH up to LED_COUNT
        if (start_reg[7])
        begin
            snake_base = start_reg + LED8;
        end
        else if (start_reg >= LED8)
        begin
            snake_base = start_reg - LED8;
        end
        else
        begin
            snake_base = start_reg;
        end
        if (!sdir_reg)
        begin
            snake_off = {1'b0, pix8} + 9'(LED8) - {1'b0, snake_base};
        end
        else
        begin
            snake_off = {1'b0, snake_base} + 9'(LED8) - {1'b0, pix8};
        end
        if (snake_off >= 9'(LED8))
        begin
            snake_off = snake_off - 9'(LED8);
        end
        rel = 8'(pix8 - start_reg);
        lit = 1'b1;
        if (effect_mode <= 5'd19)
        begin
            lit = snake_off < 9'(SNK8);
            rel = snake_off[7:0];
        end
        else
        begin
            // knight: pixel within [pos, pos+len)
            lit = $signed(rel) >= 0 && rel < KNT8;
        end
    end

    always_comb
    begin
        h_in = hue_reg;
        if (fx == FX_SWIRL)
        begin
            h_in = 8'(pix8 * HUE_STRIDE_C) + phase_reg;
        end
        else if (fx == FX_SNAKE)
        begin
            h_in = base_hue + 8'(rel * HUE_STRIDE_C);
        end
        else if (fx == FX_KNIGHT)
        begin
            h_in = phase_after;
        end
    end

    rgbfx_hsv u_hsv (
        .clk (clk),
        .hue (h_in),
        .sat (base_saturation),
        .val ((fx == FX_SWIRL || fx == FX_SNAKE || fx == FX_KNIGHT) ? base_value : val_reg),
        .rgb (hsv_rgb)
    );

    // draw sweep: one pixel issued per cycle, written to the ram from the da2_reg stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
            wcnt_reg <= '0;
            dv_reg   <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                dcnt_reg <= '0;
                wcnt_reg <= '0;
                dv_reg   <= '0;
            end
            else if (cmd.draw)
            begin
                dv_reg <= {dv_reg[0], dcnt_reg <= LAST};
                if (dcnt_reg <= LAST)
                begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                if (dv_reg[1])
                begin
                    wcnt_reg <= wcnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        da1_reg  <= pix[AW-1:0];
        da2_reg  <= da1_reg;
        lit1_reg <= lit;
        lit2_reg <= lit1_reg;
        k1_reg   <= (fx == FX_KNIGHT);
        k2_reg   <= k1_reg;
    end

    assign status.draw_done = dv_reg[1] && (wcnt_reg == LAST);

    always_comb
    begin
        if (!clear_reg)
        begin
            wdata = hsv_rgb;
        end
        else if (!lit2_reg)
        begin
            wdata = '0;
        end
        else if (k2_reg)
        begin
            wdata = held_reg;
        end
        else
        begin
            wdata = hsv_rgb;
        end
    end

    assign we = cmd.draw && dv_reg[1] && paint_reg;

    // reset clears the frame store via valid bits
    logic [LED_COUNT-1:0] fvalid_reg;
    logic                 rvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvalid_reg <= '0;
        end
        else if (we)
        begin
            fvalid_reg[da2_reg] <= 1'b1;
        end
    end

    rgbfx_ram #(
        .WIDTH (24),
        .DEPTH (1 << AW)
    ) u_frame (
        .clk   (clk),
        .we    (we),
        .waddr (da2_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cleared_q = rvalid_reg ? rdata : '0;

    // knight end-of-sweep recolor uses the advanced phase
    assign phase_after = phase_reg;

    // effect state update at the update and finish phases; knight recolor needs hsv
    logic [7:0] bpos_n;
    logic [8:0] spos_s;
    logic [7:0] kpos_n;
    logic       kflip;
    logic [7:0] st;

    always_comb
    begin
        st     = m8;
        bpos_n = brise_reg ? bpos_reg + st : bpos_reg - st;
        spos_s = {spos_reg[7], spos_reg} + (interval[0] ? 9'h1ff : 9'd1);
        kpos_n = kfwd_reg ? kpos_reg + 8'd1 : kpos_reg - 8'd1;
        kflip  = ($signed(kpos_n) <= -$signed({1'b0, KNT8})) ||
                 ($signed(kpos_n) >= $signed({1'b0, LED8}));
    end

    logic recolor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            bpos_reg    <= '0;
            brise_reg   <= 1'b1;
            phase_reg   <= '0;
            spos_reg    <= 8'(9'd256 - 9'(SNK8));
            swait_reg   <= '0;
            kpos_reg    <= LED8 - 8'd1;
            kwait_reg   <= '0;
            kfwd_reg    <= 1'b1;
            recolor_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update && !skip_reg)
            begin
                recolor_reg <= 1'b0;
                case (fx)
                    FX_BREATH:
                    begin
                        bpos_reg <= bpos_n;
                        if (bpos_n < st || 9'(bpos_n) + 9'(st) > 9'(rgbfx_pkg::BREATH_LIMIT))
                        begin
                            brise_reg <= !brise_reg;
                        end
                    end
                    FX_SNAKE:
                    begin
                        if (paint_reg)
                        begin
                            swait_reg <= '0;
                        end
                        else
                        begin
                            swait_reg <= swait_reg + 8'd1;
                        end
                    end
                    FX_KNIGHT:
                    begin
                        if (paint_reg)
                        begin
                            kwait_reg <= '0;
                        end
                        else
                        begin
                            kwait_reg <= kwait_reg + 8'd1;
                        end
                    end
                    default: recolor_reg <= 1'b0;
                endcase
            end
            if (cmd.finish)
            begin
                case (fx)
                    FX_MOOD: phase_reg <= phase_reg + m8 - 8'd4;
                    FX_SWIRL:
                    begin
                        phase_reg <= phase_reg -
                            8'((interval[0] ? 8'd0 - interval : interval) << 1);
                    end
                    FX_SNAKE:
                    begin
                        if (paint_reg)
                        begin
                            if ($signed(spos_s) > $signed(9'(LED8)))
                            begin
                                spos_reg <= '0;
                            end
                            else if (spos_s[8])
                            begin
                                spos_reg <= LED8;
                            end
                            else
                            begin
                                spos_reg <= spos_s[7:0];
                            end
                        end
                    end
                    FX_KNIGHT:
                    begin
                        if (paint_reg)
                        begin
                            kpos_reg <= kpos_n;
                            if (kflip)
                            begin
                                kfwd_reg    <= !kfwd_reg;
                                phase_reg   <= phase_reg + HUE_STRIDE_C;
                                recolor_reg <= 1'b1;
                            end
                        end
                    end
                    default: phase_reg <= phase_reg;
                endcase
                if (newheld_reg && paint_reg)
                begin
                    held_reg <= wdata;
                end
            end
            // knight recolor: hsv of the new phase is taken from the hsv output once rcnt_reg reaches 2
            if (cmd.emit && recolor_reg && rcnt_reg == CW'(2))
            begin
                held_reg    <= hsv_rgb;
                recolor_reg <= 1'b0;
            end
        end
    end

    // emit: read one pixel per cycle into the output register while the output is not stalled
    logic can_load;
    assign can_load = !ov_reg || out_if.ready;
    // a read waiting on a stalled output keeps its address on the ram port
    assign raddr    = (rpend_reg && !can_load) ? rpix_reg : rcnt_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcnt_reg       <= '0;
            rpend_reg      <= 1'b0;
            ov_reg         <= 1'b0;
            olast_reg      <= 1'b0;
            olast_pend_reg <= 1'b0;
            rvalid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.emit && rpend_reg && can_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_if.ready)
            begin
                ov_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                rcnt_reg  <= '0;
                rpend_reg <= 1'b0;
            end
            else if (cmd.emit)
            begin
                if (rpend_reg && can_load)
                begin
                    orgb_reg  <= cleared_q;
                    opix_reg  <= rpix_reg;
                    olast_reg <= olast_pend_reg;
                end
                if ((!rpend_reg || can_load) && rcnt_reg <= LAST)
                begin
                    rpend_reg      <= 1'b1;
                    rpix_reg       <= rcnt_reg[AW-1:0];
                    rvalid_reg     <= fvalid_reg[rcnt_reg[AW-1:0]];
                    olast_pend_reg <= (rcnt_reg == LAST);
                    rcnt_reg       <= rcnt_reg + 1'b1;
                end
                else if (rpend_reg && can_load)
                begin
                    rpend_reg <= 1'b0;
                end
            end
        end
    end

    assign status.emit_done = out_if.ready && ov_reg && olast_reg;

    assign out_if.valid   = ov_reg;
    assign out_if.payload = {4'(opix_reg), orgb_reg, olast_reg};
endmodule

// ===== dv/tb_rgb_led_effect_generator.sv =====
module tb_rgb_led_effect_generator;

    localparam int LEDS      = 16;
    localparam int SNAKE_LEN = 4;
    localparam int BAR_LEN   = 3;
    // output payload: pixel_index, red, green, blue, frame_end (msb first)
    localparam int OUT_W     = 29;
    // enough cycles for an ignored or still-running request to settle
    localparam int SETTLE    = 2 * LEDS + 30;

    // one pixel of a frame
    typedef struct packed {
        logic [3:0] pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_t;

    // expected pixels plus a private copy of the effect engine
    class frame_scoreboard;
        pixel_t     pending[$];
        int         errors;
        // register copies
        bit         enable;
        logic [4:0] mode;
        logic [7:0] hue, sat, val;
        // effect state
        logic [23:0] frame[LEDS];
        logic [23:0] held;
        logic [7:0]  breath_pos;
        bit          breath_up;
        logic [7:0]  phase;
        logic [7:0]  snake_pos, snake_wait;
        logic [7:0]  bar_pos, bar_wait;
        bit          bar_fwd;

        function new();
            enable = 0;
            mode = 5'd8;
            hue = 8'd214;
            sat = 8'd255;
            val = 8'd255;
            foreach (frame[i]) frame[i] = '0;
            held = '0;
            breath_pos = '0;
            breath_up = 1;
            phase = '0;
            snake_pos = 8'(256 - SNAKE_LEN);
            snake_wait = '0;
            bar_pos = 8'(LEDS - 1);
            bar_wait = '0;
            bar_fwd = 1;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] data);
            case (idx)
                rgbfx_pkg::REG_LIGHT_ENABLE: enable = data[0];
                rgbfx_pkg::REG_EFFECT_MODE:  mode = data[4:0];
                rgbfx_pkg::REG_BASE_HUE:     hue = data;
                rgbfx_pkg::REG_BASE_SAT:     sat = data;
                rgbfx_pkg::REG_BASE_VALUE:   val = data;
                default: ;
            endcase
        endfunction

        // constant-brightness hsv, packed r:g:b
        function logic [23:0] hsv_rgb(logic [7:0] h, logic [7:0] s, logic [7:0] v);
            int unsigned h3, sect, x, lo;
            logic [7:0] t[5];
            h3 = h * 3;
            sect = h3 >> 8;
            x = ((((h3 & 255) * s) >> 8) * v) >> 8;
            lo = ((256 - s) * v) >> 8;
            t[0] = 8'(x + lo);
            t[3] = t[0];
            t[1] = 8'(v - x);
            t[4] = t[1];
            t[2] = 8'(lo);
            return {t[sect + 1], t[sect], t[sect + 2]};
        endfunction

        function void fill(logic [7:0] h, logic [7:0] s, logic [7:0] v);
            held = hsv_rgb(h, s, v);
            foreach (frame[i]) frame[i] = held;
        endfunction

        function void breathe(logic [7:0] step);
            logic [5:0] lvl_idx;
            lvl_idx = breath_pos[5:0];
            fill(hue, sat, rgbfx_pkg::breath_level(lvl_idx));
            breath_pos = breath_up ? 8'(breath_pos + step) : 8'(breath_pos - step);
            if (breath_pos < step ||
                int'(breath_pos) + int'(step) > int'(rgbfx_pkg::BREATH_LIMIT))
                breath_up = !breath_up;
        endfunction

        function void swirl(logic [7:0] ivl);
            logic [7:0] delta;
            delta = ivl[0] ? 8'(0 - ivl) : ivl;
            foreach (frame[i])
                frame[i] = hsv_rgb(8'(rgbfx_pkg::HUE_STRIDE * i + phase), sat, val);
            phase = 8'(phase - 8'(delta * 2));
        endfunction

        function void snake(logic [7:0] ivl);
            int pos, dir, t;
            snake_wait = 8'(snake_wait + 1);
            if (snake_wait <= ivl / 2) return;
            snake_wait = '0;
            foreach (frame[i]) frame[i] = '0;
            dir = ivl[0] ? -1 : 1;
            pos = int'($signed(snake_pos));
            for (int i = 0; i < SNAKE_LEN; i++) begin
                t = (pos + i * dir) % LEDS;
                if (t < 0) t += LEDS;
                frame[t] = hsv_rgb(8'(hue + i * 16), sat, val);
            end
            pos += dir;
            if (pos > LEDS) pos = 0;
            else if (pos < 0) pos = LEDS;
            snake_pos = 8'(pos);
        endfunction

        function void knight(logic [7:0] ivl);
            int pos, t;
            bar_wait = 8'(bar_wait + 1);
            if (bar_wait <= ivl) return;
            bar_wait = '0;
            foreach (frame[i]) frame[i] = '0;
            pos = int'($signed(bar_pos));
            for (int i = 0; i < BAR_LEN; i++) begin
                t = pos + i;
                if (t >= 0 && t < LEDS) frame[t] = held;
            end
            pos += bar_fwd ? 1 : -1;
            // bounce at either end with a new colour
            if (pos <= -BAR_LEN || pos >= LEDS) begin
                bar_fwd = !bar_fwd;
                phase = 8'(phase + 16);
                held = hsv_rgb(phase, sat, val);
            end
            bar_pos = 8'(pos);
        endfunction

        // accepted tick request: advance the effect and queue the frame
        function void note_tick(bit battery_low);
            pixel_t px;
            if (battery_low || !enable) return;
            if (mode == 0) fill(hue, sat, val);
            else if (mode <= 4) breathe(8'(mode));
            else if (mode <= 7) begin
                fill(phase, sat, val);
                phase = 8'(phase + mode - 4);
            end
            else if (mode <= 13) swirl(8'(mode - 6));
            else if (mode <= 19) snake(8'(mode - 14));
            else if (mode <= 22) knight(8'(mode - 19));
            for (int i = 0; i < LEDS; i++) begin
                px.pixel = 4'(i);
                {px.red, px.green, px.blue} = frame[i];
                px.last = (i == LEDS - 1);
                pending.push_back(px);
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t exp_px;
            if (pending.size() == 0) begin
                $display("%0t: unexpected pixel %h", $time, got);
                errors++;
                return;
            end
            exp_px = pending.pop_front();
            if (got.pixel !== exp_px.pixel) begin
                $display("%0t: pixel_index exp %0d got %0d", $time, exp_px.pixel, got.pixel);
                errors++;
            end
            if (got.red !== exp_px.red) begin
                $display("%0t: red exp %0d got %0d", $time, exp_px.red, got.red);
                errors++;
            end
            if (got.green !== exp_px.green) begin
                $display("%0t: green exp %0d got %0d", $time, exp_px.green, got.green);
                errors++;
            end
            if (got.blue !== exp_px.blue) begin
                $display("%0t: blue exp %0d got %0d", $time, exp_px.blue, got.blue);
                errors++;
            end
            if (got.last !== exp_px.last) begin
                $display("%0t: frame_end exp %0d got %0d", $time, exp_px.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [rgbfx_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rgbfx_pkg::CFG_DATA_W-1:0] cfg_data;

    rgbfx_stream_if #(.WIDTH(1))     tick_ch ();
    rgbfx_stream_if #(.WIDTH(OUT_W)) pix_ch ();

    rgb_led_effect_generator #(
        .LED_COUNT    (LEDS),
        .SNAKE_LENGTH (SNAKE_LEN),
        .KNIGHT_LENGTH(BAR_LEN)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_if    (tick_ch.sink),
        .out_if   (pix_ch.source),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    frame_scoreboard sb;
    bit quiet;        // when set, neither side idles
    int stall_left;
    int live_ticks;   // ticks that actually produce a frame

    initial clk = 0;
    always #5 clk = ~clk;

    // hard stop well beyond the slowest legal run
    initial
    begin
        #60000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // pixel sink: random stalls, mostly short, a few long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pix_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (quiet) begin
            pix_ch.ready <= 1'b1;
        end
        else if (stall_left > 0) begin
            pix_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 70) begin
            pix_ch.ready <= 1'b1;
        end
        else begin
            pix_ch.ready <= 1'b0;
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 3);
        end
    end

    // every accepted pixel is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pix_ch.valid && pix_ch.ready)
            sb.check_pixel(pix_ch.payload);
    end

    // one register write; cfg_we is low again when the task returns
    task automatic write_reg(logic [2:0] idx, logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // one tick request; valid stays high straight into the next tick when no gap
    task automatic send_tick(bit battery_low);
        int gap;
        gap = quiet ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                       : $urandom_range(0, 2));
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.payload <= battery_low;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        sb.note_tick(battery_low);
        if (!battery_low && sb.enable) live_ticks++;
    endtask

    // let every queued pixel drain and any ignored request finish
    task automatic settle();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // one phase: program all registers, then a run of ticks
    task automatic run_phase(bit en, logic [7:0] mode, logic [7:0] hue_v,
                             logic [7:0] sat_v, logic [7:0] val_v,
                             int ticks, int low_pct);
        settle();
        write_reg(rgbfx_pkg::REG_LIGHT_ENABLE, {7'd0, en});
        write_reg(rgbfx_pkg::REG_EFFECT_MODE, mode);
        write_reg(rgbfx_pkg::REG_BASE_HUE, hue_v);
        write_reg(rgbfx_pkg::REG_BASE_SAT, sat_v);
        write_reg(rgbfx_pkg::REG_BASE_VALUE, val_v);
        repeat (ticks) send_tick($urandom_range(0, 99) < low_pct);
    endtask

    initial
    begin
        sb = new();
        quiet = 0;
        live_ticks = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tick_ch.valid = 1'b0;
        tick_ch.payload = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: disabled, so nothing comes out
        send_tick(1'b0);
        // battery low while enabled is ignored too
        run_phase(1, 8'd8, 8'd214, 8'd255, 8'd255, 0, 0);
        send_tick(1'b1);
        // static at both extremes of hue, saturation and value
        run_phase(1, 8'd0, 8'd0, 8'd0, 8'd0, 1, 0);
        run_phase(1, 8'd0, 8'd255, 8'd255, 8'd255, 1, 0);
        // slowest and fastest breathing, mood, swirl
        run_phase(1, 8'd1, 8'd85, 8'd200, 8'd255, 2, 0);
        run_phase(1, 8'd4, 8'd170, 8'd255, 8'd10, 2, 0);
        run_phase(1, 8'd5, 8'd3, 8'd255, 8'd255, 1, 0);
        run_phase(1, 8'd7, 8'd3, 8'd128, 8'd255, 1, 0);
        run_phase(1, 8'd8, 8'd0, 8'd255, 8'd255, 1, 0);
        run_phase(1, 8'd13, 8'd0, 8'd255, 8'd128, 1, 0);
        // snake both directions, knight fastest and slowest
        run_phase(1, 8'd14, 8'd240, 8'd255, 8'd255, 2, 0);
        run_phase(1, 8'd19, 8'd240, 8'd255, 8'd255, 2, 0);
        run_phase(1, 8'd20, 8'd0, 8'd255, 8'd255, 2, 0);
        run_phase(1, 8'd22, 8'd0, 8'd255, 8'd255, 3, 0);
        // unassigned modes just replay the frame store
        run_phase(1, 8'd23, 8'd0, 8'd255, 8'd255, 1, 0);
        run_phase(1, 8'd31, 8'd0, 8'd255, 8'd255, 1, 0);

        // random phases; long runs let breathing reverse and the bars wrap and bounce
        live_ticks = 0;
        while (live_ticks < 400) begin
            quiet = ($urandom_range(0, 5) == 0);
            run_phase($urandom_range(0, 9) != 0,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(23, 31)
                                                  : $urandom_range(0, 22),
                      $urandom_range(0, 255),
                      ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 255)),
                      ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255)),
                      $urandom_range(4, 60), 10);
        end
        quiet = 0;

        settle();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/rgbfx_pkg.sv
rtl/core/rgbfx_stream_if.sv
rtl/core/rgbfx_hsv.sv
rtl/core/rgbfx_ram.sv
rtl/core/rgbfx_ctrl.sv
rtl/core/rgbfx_datapath.sv
rtl/core/rgb_led_effect_generator.sv
dv/tb_rgb_led_effect_generator.sv
